[sv/sfc_pkg.sv]
// ----------------------------------------------------------------------------
// sfc_pkg: shared types and constants of the signed integer format converter
// Format and status codes, the stage payload that flows down the cell chain,
// and elaboration-time helpers.
// ----------------------------------------------------------------------------
package sfc_pkg;

    localparam int WORD_W             = 32;
    localparam int ACC_W              = 30;
    localparam int DEF_DECIMAL_DIGITS = 6;
    localparam int DEF_DIGIT_BITS     = 5;
    localparam int CFG_INDEX_W        = 2;
    localparam int CFG_DATA_W         = 2;

    localparam logic [WORD_W-1:0] WORD_MSB   = 32'h8000_0000;
    localparam logic [WORD_W-1:0] MAG_MAX    = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] RECIP_10   = 32'hCCCC_CCCD;
    localparam int                RECIP_SHIFT = 35;
    localparam logic [1:0]        DEC_SIGN_NEG = 2'b11;
    localparam logic [1:0]        DEC_SIGN_POS = 2'b00;

    typedef enum logic [1:0] {
        FMT_ONES = 2'd0,
        FMT_TWOS = 2'd1,
        FMT_SMAG = 2'd2,
        FMT_DEC  = 2'd3
    } fmt_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDEF = 2'd1,
        ST_ERR   = 2'd2
    } status_t;

    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_FORMAT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_FORMAT = 2'd1;

    // Payload of one transaction as it moves through the chain.
    typedef struct packed {
        fmt_t               src;
        fmt_t               tgt;
        logic [WORD_W-1:0]  word;
        logic               neg;
        logic [WORD_W-1:0]  mag;
        status_t            status;
        logic [ACC_W-1:0]   acc;
    } stage_t;

    // Ten to the power n, for elaboration-time limits.
    function automatic logic [WORD_W-1:0] pow10(input int n);
        logic [WORD_W-1:0] result;
        result = 32'd1;
        for (int i = 0; i < n; i++) begin
            result = result * 32'd10;
        end
        return result;
    endfunction

endpackage

[sv/sfc_in_if.sv]
// ----------------------------------------------------------------------------
// sfc_in_if: input word channel
// Valid/ready channel carrying one word in the source format.
// ----------------------------------------------------------------------------
interface sfc_in_if;
    import sfc_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word_in;

    modport source (output valid, output word_in, input ready);
    modport sink   (input valid, input word_in, output ready);
endinterface

[sv/sfc_out_if.sv]
// ----------------------------------------------------------------------------
// sfc_out_if: result channel
// Valid/ready channel carrying the converted word and its status.
// ----------------------------------------------------------------------------
interface sfc_out_if;
    import sfc_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word_out;
    logic [1:0]        status;

    modport source (output valid, output word_out, output status, input ready);
    modport sink   (input valid, input word_out, input status, output ready);
endinterface

[sv/sfc_cfg_if.sv]
// ----------------------------------------------------------------------------
// sfc_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface sfc_cfg_if;
    import sfc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/sfc_front.sv]
// ----------------------------------------------------------------------------
// sfc_front: decode stage
// Split the source word into sign and magnitude and flag early failures.
// ----------------------------------------------------------------------------
module sfc_front #(
    parameter int DECIMAL_DIGITS = sfc_pkg::DEF_DECIMAL_DIGITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        up_valid,
    output logic                        up_ready,
    input  logic [sfc_pkg::WORD_W-1:0]  word_in,
    input  sfc_pkg::fmt_t               src_fmt,
    input  sfc_pkg::fmt_t               tgt_fmt,
    output logic                        dn_valid,
    input  logic                        dn_ready,
    output sfc_pkg::stage_t             dn_stage
);
    import sfc_pkg::*;

    localparam logic [WORD_W-1:0] DEC_LIMIT = pow10(DECIMAL_DIGITS);

    logic   valid_reg;
    stage_t stage_reg;
    stage_t stage_next;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_stage = stage_reg;

    always_comb
    begin
        stage_next        = '0;
        stage_next.src    = src_fmt;
        stage_next.tgt    = tgt_fmt;
        stage_next.word   = word_in;
        stage_next.neg    = word_in[WORD_W-1];
        stage_next.status = ST_OK;
        unique case (src_fmt)
            FMT_ONES: stage_next.mag = word_in[WORD_W-1] ?
                                       {1'b0, ~word_in[WORD_W-2:0]} : word_in;
            FMT_TWOS: stage_next.mag = word_in[WORD_W-1] ?
                                       (~word_in + 32'd1) : word_in;
            FMT_SMAG: stage_next.mag = {1'b0, word_in[WORD_W-2:0]};
            FMT_DEC:
            begin
                // Digits are summed by the cells; only the sign field here.
                stage_next.neg = (word_in[WORD_W-1:WORD_W-2] == DEC_SIGN_NEG);
                if (word_in[WORD_W-1] ^ word_in[WORD_W-2])
                begin
                    stage_next.neg    = 1'b0;
                    stage_next.status = ST_ERR;
                end
            end
            default: stage_next.mag = '0;
        endcase
        if (tgt_fmt == FMT_DEC && src_fmt != FMT_DEC && stage_next.mag >= DEC_LIMIT)
        begin
            stage_next.status = ST_UNDEF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            stage_reg <= stage_next;
        end
    end

    a_bad_sign_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        up_valid && up_ready && src_fmt == FMT_DEC && tgt_fmt != FMT_DEC &&
        (word_in[WORD_W-1] ^ word_in[WORD_W-2])
        |=> dn_valid && dn_stage.status == ST_ERR)
        else $error("bad decimal sign field not flagged");

endmodule

[sv/sfc_cell.sv]
// ----------------------------------------------------------------------------
// sfc_cell: one decimal digit cell
// Fold one decimal digit into the magnitude, or peel one digit off it.
// ----------------------------------------------------------------------------
module sfc_cell #(
    parameter int DECIMAL_DIGITS = sfc_pkg::DEF_DECIMAL_DIGITS,
    parameter int DIGIT_BITS     = sfc_pkg::DEF_DIGIT_BITS,
    parameter int CELL_INDEX     = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_ready,
    input  sfc_pkg::stage_t up_stage,
    output logic            dn_valid,
    input  logic            dn_ready,
    output sfc_pkg::stage_t dn_stage
);
    import sfc_pkg::*;

    // Decoding walks the digits most significant first; encoding least first.
    localparam int SRC_POS = (DECIMAL_DIGITS - 1 - CELL_INDEX) * DIGIT_BITS;
    localparam int DST_POS = CELL_INDEX * DIGIT_BITS;

    logic                    valid_reg;
    stage_t                  stage_reg;
    stage_t                  stage_next;
    logic [DIGIT_BITS-1:0]   digit;
    logic [2*WORD_W-1:0]     product;
    logic [WORD_W-1:0]       quot;
    logic [WORD_W-1:0]       rem;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_stage = stage_reg;

    assign digit   = up_stage.word[SRC_POS +: DIGIT_BITS];
    assign product = {{WORD_W{1'b0}}, up_stage.mag} * {{WORD_W{1'b0}}, RECIP_10};
    assign quot    = WORD_W'(product >> RECIP_SHIFT);
    assign rem     = up_stage.mag - ((quot << 3) + (quot << 1));

    always_comb
    begin
        stage_next = up_stage;
        if (up_stage.src != up_stage.tgt)
        begin
            if (up_stage.src == FMT_DEC)
            begin
                stage_next.mag = (up_stage.mag << 3) + (up_stage.mag << 1)
                               + WORD_W'(digit);
            end
            else if (up_stage.tgt == FMT_DEC)
            begin
                stage_next.acc[DST_POS +: DIGIT_BITS] = rem[DIGIT_BITS-1:0];
                stage_next.mag = quot;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

[sv/sfc_back.sv]
// ----------------------------------------------------------------------------
// sfc_back: encode stage and output register
// Apply range checks, encode the target format and hold the result.
// ----------------------------------------------------------------------------
module sfc_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        up_valid,
    output logic                        up_ready,
    input  sfc_pkg::stage_t             up_stage,
    output logic                        dn_valid,
    input  logic                        dn_ready,
    output logic [sfc_pkg::WORD_W-1:0]  word_out,
    output sfc_pkg::status_t            status
);
    import sfc_pkg::*;

    logic              valid_reg;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    status_t           status_reg;
    status_t           status_next;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign word_out = word_reg;
    assign status   = status_reg;

    always_comb
    begin
        word_next   = '0;
        status_next = up_stage.status;
        if (up_stage.src == up_stage.tgt)
        begin
            word_next   = up_stage.word;
            status_next = ST_OK;
        end
        else if (up_stage.status == ST_OK)
        begin
            unique case (up_stage.tgt)
                FMT_ONES:
                begin
                    if (up_stage.mag > MAG_MAX)
                        status_next = ST_UNDEF;
                    else
                        word_next = up_stage.neg ? ~up_stage.mag : up_stage.mag;
                end
                FMT_TWOS:
                begin
                    if (up_stage.mag > (up_stage.neg ? WORD_MSB : MAG_MAX))
                        status_next = ST_UNDEF;
                    else
                        word_next = up_stage.neg ? (~up_stage.mag + 32'd1) : up_stage.mag;
                end
                FMT_SMAG:
                begin
                    if (up_stage.mag > MAG_MAX)
                        status_next = ST_UNDEF;
                    else
                        word_next = {up_stage.neg, up_stage.mag[WORD_W-2:0]};
                end
                FMT_DEC:
                begin
                    word_next = {(up_stage.neg ? DEC_SIGN_NEG : DEC_SIGN_POS), up_stage.acc};
                end
                default: word_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            word_reg   <= word_next;
            status_reg <= status_next;
        end
    end

    a_same_format_passes: assert property (@(posedge clk) disable iff (!rst_n)
        up_valid && up_ready && up_stage.src == up_stage.tgt
        |=> valid_reg && status_reg == ST_OK && word_reg == $past(up_stage.word))
        else $error("equal formats did not pass the word through");

    a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
        up_valid && up_ready && up_stage.src != up_stage.tgt &&
        up_stage.status == ST_UNDEF
        |=> valid_reg && status_reg == ST_UNDEF && word_reg == '0)
        else $error("early undefined flag lost at output");

endmodule

[sv/signed_integer_format_converter.sv]
// ----------------------------------------------------------------------------
// signed_integer_format_converter: 32-bit signed representation converter
// Converts words between ones' complement, two's complement, sign-magnitude
// and a signed decimal form, one transaction per clock unless the receiver stalls.
// ----------------------------------------------------------------------------
// Usage:
//   cfg  : write source_format (index 0) and target_format (index 1) while
//          no transaction is in flight; always ready.
//   din  : one 32-bit word per transaction in the source format.
//   dout : converted word plus status (ok, undefined, error); word is zero
//          unless status is ok.
// The chain is one decode stage, one cell per decimal digit and one
// encode/output stage. Throughput is one transaction per cycle unless the
// receiver stalls; each digit cell either folds one decimal digit into the
// magnitude or peels one off with a reciprocal multiply, so the digit count
// sets the depth.
// Reset empties the chain and returns both formats to two's complement.
// When the receiver stalls, the output register holds its result and each
// stage keeps accepting until it is full, so bubbles are squeezed out before
// din sees backpressure.
// ----------------------------------------------------------------------------
module signed_integer_format_converter #(
    parameter int DECIMAL_DIGITS = sfc_pkg::DEF_DECIMAL_DIGITS,
    parameter int DIGIT_BITS     = sfc_pkg::DEF_DIGIT_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    sfc_in_if.sink       din,
    sfc_out_if.source    dout,
    sfc_cfg_if.sink      cfg
);
    import sfc_pkg::*;

    fmt_t   src_fmt_reg;
    fmt_t   tgt_fmt_reg;

    // Stage k feeds cell k; the last entry feeds the output stage.
    stage_t chain_stage [DECIMAL_DIGITS+1];
    logic   chain_valid [DECIMAL_DIGITS+1];
    logic   chain_ready [DECIMAL_DIGITS+1];
    status_t out_status;

    // Configuration registers: always ready, ignore unknown indexes.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_fmt_reg <= FMT_TWOS;
            tgt_fmt_reg <= FMT_TWOS;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SOURCE_FORMAT: src_fmt_reg <= fmt_t'(cfg.data);
                REG_TARGET_FORMAT: tgt_fmt_reg <= fmt_t'(cfg.data);
                default: ;
            endcase
        end
    end

    // Decode: sign, magnitude and early status.
    sfc_front #(
        .DECIMAL_DIGITS (DECIMAL_DIGITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (din.valid),
        .up_ready (din.ready),
        .word_in  (din.word_in),
        .src_fmt  (src_fmt_reg),
        .tgt_fmt  (tgt_fmt_reg),
        .dn_valid (chain_valid[0]),
        .dn_ready (chain_ready[0]),
        .dn_stage (chain_stage[0])
    );

    // Digit cells: one per decimal digit.
    for (genvar k = 0; k < DECIMAL_DIGITS; k++)
    begin : g_cell
        sfc_cell #(
            .DECIMAL_DIGITS (DECIMAL_DIGITS),
            .DIGIT_BITS     (DIGIT_BITS),
            .CELL_INDEX     (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[k]),
            .up_ready (chain_ready[k]),
            .up_stage (chain_stage[k]),
            .dn_valid (chain_valid[k+1]),
            .dn_ready (chain_ready[k+1]),
            .dn_stage (chain_stage[k+1])
        );
    end

    // Encode and hold the result for the receiver.
    sfc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (chain_valid[DECIMAL_DIGITS]),
        .up_ready (chain_ready[DECIMAL_DIGITS]),
        .up_stage (chain_stage[DECIMAL_DIGITS]),
        .dn_valid (dout.valid),
        .dn_ready (dout.ready),
        .word_out (dout.word_out),
        .status   (out_status)
    );

    assign dout.status = out_status;

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: signed integer format converter
// Drives words through every source/target format pair under random valid and
// ready gaps, predicts each converted word and status, and checks each result
// in order as it leaves the block.
// ----------------------------------------------------------------------------
module testbench;
    import sfc_pkg::*;

    localparam int NDIG       = DEF_DECIMAL_DIGITS;
    localparam int DBITS      = DEF_DIGIT_BITS;
    localparam int LATENCY    = NDIG + 2;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 60;
    localparam int PHASE_ITEMS = 13;

    // One converted word with its status.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        status_t           status;
    } conversion_t;

    // One directed case: the formats it needs and the word to convert.
    typedef struct {
        fmt_t              src;
        fmt_t              tgt;
        logic [WORD_W-1:0] word;
    } directed_case_t;

    // ------------------------------------------------------------------------
    // Conversion scoreboard: keeps its own copy of both format registers,
    // predicts the result of every accepted word and checks results in order.
    // ------------------------------------------------------------------------
    class conversion_scoreboard;
        fmt_t        src_fmt;
        fmt_t        tgt_fmt;
        conversion_t pending_results[$];
        int          mismatches;

        function new();
            src_fmt    = FMT_TWOS;
            tgt_fmt    = FMT_TWOS;
            mismatches = 0;
        endfunction

        // Split a word into sign and magnitude.
        static function status_t decode_word(input fmt_t f, input logic [WORD_W-1:0] w,
                                             output logic neg, output logic [63:0] mag);
            logic [1:0]  sign_field;
            logic [63:0] weight;
            sign_field = w[31:30];
            neg        = w[31];
            mag        = '0;
            weight     = 64'd1;
            case (f)
                FMT_ONES: mag = neg ? {33'd0, ~w[30:0]} : {32'd0, w};
                FMT_TWOS: mag = neg ? {32'd0, (~w + 32'd1)} : {32'd0, w};
                FMT_SMAG: mag = {33'd0, w[30:0]};
                default:
                begin
                    if (sign_field != DEC_SIGN_NEG && sign_field != DEC_SIGN_POS)
                    begin
                        neg = 1'b0;
                        return ST_ERR;
                    end
                    neg = (sign_field == DEC_SIGN_NEG);
                    // digits above nine are weighted as they stand
                    for (int i = 0; i < NDIG; i++)
                    begin
                        mag    = mag + weight * {59'd0, w[i*DBITS +: DBITS]};
                        weight = weight * 64'd10;
                    end
                end
            endcase
            return ST_OK;
        endfunction

        // Encode sign and magnitude in a format, or flag it as not representable.
        static function status_t encode_word(input fmt_t f, input logic neg,
                                             input logic [63:0] mag,
                                             output logic [WORD_W-1:0] w);
            logic [63:0] limit;
            logic [63:0] rest;
            w = '0;
            case (f)
                FMT_ONES:
                begin
                    if (mag > {32'd0, MAG_MAX})
                        return ST_UNDEF;
                    w = neg ? ~mag[31:0] : mag[31:0];
                end
                FMT_TWOS:
                begin
                    if (mag > {32'd0, (neg ? WORD_MSB : MAG_MAX)})
                        return ST_UNDEF;
                    w = neg ? (~mag[31:0] + 32'd1) : mag[31:0];
                end
                FMT_SMAG:
                begin
                    if (mag > {32'd0, MAG_MAX})
                        return ST_UNDEF;
                    w = {neg, mag[30:0]};
                end
                default:
                begin
                    limit = 64'd1;
                    for (int i = 0; i < NDIG; i++)
                        limit = limit * 64'd10;
                    if (mag >= limit)
                        return ST_UNDEF;
                    rest = mag;
                    for (int i = 0; i < NDIG; i++)
                    begin
                        w[i*DBITS +: DBITS] = DBITS'(rest % 64'd10);
                        rest = rest / 64'd10;
                    end
                    if (neg)
                        w[31:30] = DEC_SIGN_NEG;
                end
            endcase
            return ST_OK;
        endfunction

        static function conversion_t convert_word(input fmt_t src, input fmt_t tgt,
                                                  input logic [WORD_W-1:0] w);
            conversion_t       res;
            logic              neg;
            logic [63:0]       mag;
            logic [WORD_W-1:0] out_word;
            status_t           st;
            out_word = '0;
            if (src == tgt)
            begin
                res.word   = w;
                res.status = ST_OK;
                return res;
            end
            st = decode_word(src, w, neg, mag);
            if (st == ST_OK)
                st = encode_word(tgt, neg, mag, out_word);
            res.word   = (st == ST_OK) ? out_word : '0;
            res.status = st;
            return res;
        endfunction

        function void set_register(input logic [CFG_INDEX_W-1:0] idx, input fmt_t value);
            if (idx == REG_SOURCE_FORMAT)
                src_fmt = value;
            else if (idx == REG_TARGET_FORMAT)
                tgt_fmt = value;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        task report(input string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        function void note_input(input logic [WORD_W-1:0] w);
            pending_results.push_back(convert_word(src_fmt, tgt_fmt, w));
        endfunction

        task check_result(input logic [WORD_W-1:0] w, input logic [1:0] st);
            conversion_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result %h status %0d with nothing outstanding", w, st));
                return;
            end
            want = pending_results.pop_front();
            if (w !== want.word)
                report($sformatf("word_out %h, predicted %h", w, want.word));
            if (st !== want.status)
                report($sformatf("status %0d, predicted %0d", st, want.status));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    sfc_in_if  in_ch();
    sfc_out_if out_ch();
    sfc_cfg_if cfg_ch();

    signed_integer_format_converter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (in_ch),
        .dout  (out_ch),
        .cfg   (cfg_ch)
    );

    conversion_scoreboard sb;
    directed_case_t       directed_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_request  = 1'b0;
    int stall_cycles  = 0;

    // 12-unit clock period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Result side: ready toggles at the falling edge. On request, hold ready
    // low for a long stretch so the pipeline fills and stalls its input.
    // ------------------------------------------------------------------------
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Check every result transaction at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            sb.check_result(out_ch.word_out, out_ch.status);
    end

    // Watchdog: end the run when no channel moves a transaction for too long.
    always @(posedge clk)
    begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
            (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Offer one word, idling first at random; note it once accepted.
    // Enter and leave at a falling edge with valid still high.
    task automatic send_word(input logic [WORD_W-1:0] w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.word_in <= w;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        sb.note_input(w);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input fmt_t value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        sb.set_register(idx, value);
        @(negedge clk);
    endtask

    // Drop valid, wait until every result is back plus the pipeline depth,
    // then program both formats.
    task automatic set_formats(input fmt_t src, input fmt_t tgt);
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (LATENCY) @(negedge clk);
        write_reg(REG_SOURCE_FORMAT, src);
        write_reg(REG_TARGET_FORMAT, tgt);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic void add_case(input fmt_t src, input fmt_t tgt,
                                     input logic [WORD_W-1:0] w);
        directed_case_t c;
        c.src  = src;
        c.tgt  = tgt;
        c.word = w;
        directed_q.push_back(c);
    endfunction

    // Random word for a source format: mostly well-formed values near the
    // interesting magnitudes, the rest raw noise. Decimal sources get legal
    // digit strings, out-of-range digits and bad sign fields.
    function automatic logic [WORD_W-1:0] make_word(input fmt_t src);
        logic [WORD_W-1:0] w;
        logic [63:0]       mag;
        logic              neg;
        logic [1:0]        bad_sign;
        int                pick;
        status_t           st;
        pick     = $urandom_range(0, 9);
        neg      = 1'($urandom_range(0, 1));
        bad_sign = 2'($urandom_range(1, 2));
        w        = $urandom;
        if (pick < 3)
            return w;
        if (src == FMT_DEC)
        begin
            w = '0;
            for (int i = 0; i < NDIG; i++)
                w[i*DBITS +: DBITS] = (pick == 8) ? DBITS'($urandom_range(0, 31))
                                                  : DBITS'($urandom_range(0, 9));
            if (pick == 9)
                w[31:30] = bad_sign;
            else
                w[31:30] = neg ? DEC_SIGN_NEG : DEC_SIGN_POS;
            return w;
        end
        case (pick)
            6:       mag = 64'd999990 + 64'($urandom_range(0, 20));
            7:       mag = 64'h7FFF_FFF0 + 64'($urandom_range(0, 31));
            8:       mag = 64'($urandom_range(0, 15));
            9:       mag = 64'($urandom);
            default: mag = 64'($urandom_range(0, 999999));
        endcase
        st = conversion_scoreboard::encode_word(src, neg, mag, w);
        // only a negative two's word reaches magnitude 2^31
        if (st != ST_OK)
            w = WORD_MSB;
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int   combo;
        int   count;
        fmt_t src;
        fmt_t tgt;

        sb            = new();
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.word_in = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = REG_SOURCE_FORMAT;
        cfg_ch.data   = FMT_TWOS;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: the most negative two's word has no ones' or sign-magnitude form
        add_case(FMT_TWOS, FMT_ONES, 32'h8000_0000);
        add_case(FMT_TWOS, FMT_SMAG, 32'h8000_0000);
        add_case(FMT_TWOS, FMT_ONES, 32'h7FFF_FFFF);
        add_case(FMT_TWOS, FMT_SMAG, 32'h8000_0001);
        // negative zero keeps its sign except in two's complement
        add_case(FMT_ONES, FMT_TWOS, 32'hFFFF_FFFF);
        add_case(FMT_ONES, FMT_SMAG, 32'hFFFF_FFFF);
        add_case(FMT_ONES, FMT_DEC,  32'hFFFF_FFFF);
        add_case(FMT_SMAG, FMT_ONES, 32'h8000_0000);
        add_case(FMT_DEC,  FMT_ONES, 32'hC000_0000);
        // bad decimal sign fields, and pass-through even then
        add_case(FMT_DEC,  FMT_TWOS, 32'h4000_0000);
        add_case(FMT_DEC,  FMT_TWOS, 32'h8000_0000);
        add_case(FMT_DEC,  FMT_DEC,  32'h4000_0000);
        // decimal digits above nine are weighted as they stand
        add_case(FMT_DEC,  FMT_TWOS, 32'h3FFF_FFFF);
        add_case(FMT_DEC,  FMT_SMAG, 32'hDEAD_BEEF);
        // decimal range edges
        add_case(FMT_TWOS, FMT_DEC,  32'd999999);
        add_case(FMT_TWOS, FMT_DEC,  32'd1000000);
        add_case(FMT_TWOS, FMT_DEC,  32'hFFF0_BDC1);
        add_case(FMT_TWOS, FMT_DEC,  32'hFFF0_BDC0);
        add_case(FMT_SMAG, FMT_DEC,  32'h800F_423F);
        add_case(FMT_ONES, FMT_TWOS, 32'h8000_0000);
        add_case(FMT_SMAG, FMT_TWOS, 32'hFFFF_FFFF);
        add_case(FMT_ONES, FMT_ONES, 32'h1234_5678);
        add_case(FMT_TWOS, FMT_TWOS, 32'h0000_0000);
        add_case(FMT_SMAG, FMT_TWOS, 32'h0000_0000);

        foreach (directed_q[i])
        begin
            if (directed_q[i].src != sb.src_fmt || directed_q[i].tgt != sb.tgt_fmt)
                set_formats(directed_q[i].src, directed_q[i].tgt);
            send_word(directed_q[i].word);
        end

        // Random: every format pair under each idling pattern
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 16; k++)
            begin
                combo = (k + r * 5) % 16;
                src   = fmt_t'(combo[1:0]);
                tgt   = fmt_t'(combo[3:2]);
                set_formats(src, tgt);
                case (r)
                    0:
                    begin
                        send_idle_pct = 22;
                        recv_idle_pct = 74;
                    end
                    1:
                    begin
                        send_idle_pct = 74;
                        recv_idle_pct = 22;
                    end
                    default:
                    begin
                        send_idle_pct = 0;
                        recv_idle_pct = 0;
                    end
                endcase
                count = PHASE_ITEMS;
                // back the result side up while words keep coming
                if (r == 2 && k == 3)
                begin
                    hold_request = 1'b1;
                    count        = 30;
                end
                repeat (count) send_word(make_word(src));
            end
        end

        // Drain: wait for every outstanding result, then a little longer for
        // anything unexpected still in the pipeline.
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (LATENCY * 2) @(negedge clk);

        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
